// File: hdl/dfq_pkg.sv
`default_nettype none

package dfq_pkg;

   // Field widths of the request and response
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DATE_W  = YEAR_W + MONTH_W + DAY_W;
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned STAT_W  = 2;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE    = 2'd0,
      CMD_DEQ_OLDEST = 2'd1,
      CMD_DEQ_FIRST  = 2'd2,
      CMD_DEQ_SECOND = 2'd3
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

// File: hdl/dfq_if.sv
`default_nettype none

interface dfq_req_if
   import dfq_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic               kind;
   logic [DAY_W-1:0]   day;
   logic [MONTH_W-1:0] month;
   logic [YEAR_W-1:0]  year;

   modport source (output valid, command, kind, day, month, year, input ready);
   modport sink   (input valid, command, kind, day, month, year, output ready);
endinterface

interface dfq_rsp_if
   import dfq_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic               out_kind;
   logic [DAY_W-1:0]   out_day;
   logic [MONTH_W-1:0] out_month;
   logic [YEAR_W-1:0]  out_year;

   modport source (output valid, status, out_kind, out_day, out_month, out_year,
                   input ready);
   modport sink   (input valid, status, out_kind, out_day, out_month, out_year,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/dual_fifo_oldest_first_dequeue.sv
`default_nettype none

// Two-class oldest-first queue. Requests on req_ch either enqueue a date
// (day, month, year) into the queue of class kind, dequeue the older of the
// two queue heads (year, then month, then day; class 1 wins a tie), or dequeue
// a named class. Every request gives exactly one response on rsp_ch: status
// OK, EMPTY when the requested queue(s) hold nothing (state unchanged), or
// FULL when an enqueue is dropped. Each class keeps QUEUE_DEPTH entries in a
// ring buffer held in a synchronous memory. A request is captured in S_IDLE,
// as both queue heads are read from the memories; S_EXEC then decides,
// updates the pointers, writes any enqueued date and loads the response
// register. The block takes no new request until S_EXEC is done; a
// response left waiting stalls only the request after it, in S_EXEC. The
// memories need no clearing after reset.
module dual_fifo_oldest_first_dequeue
   import dfq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   dfq_req_if.sink    req_ch,
   dfq_rsp_if.source  rsp_ch
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Queue storage
   logic [DATE_W-1:0] first_mem  [QUEUE_DEPTH];
   logic [DATE_W-1:0] second_mem [QUEUE_DEPTH];

   state_type         state_ff, state_in;
   command_type       cmd_ff;
   logic              kind_ff;
   logic [DATE_W-1:0] date_ff;

   logic [PTR_W-1:0]  first_head_ff, first_head_in, first_tail_ff, first_tail_in;
   logic [PTR_W-1:0]  second_head_ff, second_head_in, second_tail_ff, second_tail_in;
   logic [CNT_W-1:0]  first_count_ff, first_count_in, second_count_ff, second_count_in;
   logic [DATE_W-1:0] first_rd_ff, second_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [DATE_W-1:0] rsp_date_ff, rsp_date_in;

   logic              req_fire, exec_go;
   logic              first_empty, second_empty, first_full, second_full;
   logic              first_wr, second_wr;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1))
         r = '0;
      else
         r = p + PTR_W'(1);
      return r;
   endfunction

   assign req_fire = req_ch.valid && req_ch.ready;
   assign exec_go  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign first_empty  = (first_count_ff == '0);
   assign second_empty = (second_count_ff == '0);
   assign first_full   = (first_count_ff == CNT_W'(QUEUE_DEPTH));
   assign second_full  = (second_count_ff == CNT_W'(QUEUE_DEPTH));

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= command_type'(req_ch.command);
         kind_ff <= req_ch.kind;
         date_ff <= {req_ch.year, req_ch.month, req_ch.day};
      end
   end

   // Read both heads every cycle; pointers only move at commit
   always_ff @(posedge clock) begin
      first_rd_ff  <= first_mem[first_head_ff];
      second_rd_ff <= second_mem[second_head_ff];
   end

   always_ff @(posedge clock) begin
      if (first_wr)
         first_mem[first_tail_ff] <= date_ff;
      if (second_wr)
         second_mem[second_tail_ff] <= date_ff;
   end

   // Decide, update pointers and build the response
   always_comb begin
      logic pick;
      logic pop;
      pick            = 1'b0;
      pop             = 1'b0;
      state_in        = state_ff;
      first_wr        = 1'b0;
      second_wr       = 1'b0;
      first_head_in   = first_head_ff;
      first_tail_in   = first_tail_ff;
      first_count_in  = first_count_ff;
      second_head_in  = second_head_ff;
      second_tail_in  = second_tail_ff;
      second_count_in = second_count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_date_in     = rsp_date_ff;

      if (rsp_valid_ff && rsp_ch.ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire)
               state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_kind_in   = 1'b0;
               rsp_date_in   = '0;
               case (cmd_ff)
                  CMD_ENQUEUE: begin
                     if (kind_ff) begin
                        if (second_full) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           second_wr       = 1'b1;
                           second_tail_in  = ptr_next(second_tail_ff);
                           second_count_in = second_count_ff + CNT_W'(1);
                        end
                     end else begin
                        if (first_full) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           first_wr       = 1'b1;
                           first_tail_in  = ptr_next(first_tail_ff);
                           first_count_in = first_count_ff + CNT_W'(1);
                        end
                     end
                  end
                  CMD_DEQ_OLDEST: begin
                     if (first_empty && second_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        pop = 1'b1;
                        if (first_empty)
                           pick = 1'b1;
                        else if (second_empty)
                           pick = 1'b0;
                        else
                           pick = !(first_rd_ff < second_rd_ff);
                     end
                  end
                  CMD_DEQ_FIRST: begin
                     pick = 1'b0;
                     if (first_empty)
                        rsp_status_in = STAT_EMPTY;
                     else
                        pop = 1'b1;
                  end
                  CMD_DEQ_SECOND: begin
                     pick = 1'b1;
                     if (second_empty)
                        rsp_status_in = STAT_EMPTY;
                     else
                        pop = 1'b1;
                  end
                  default: begin
                     rsp_status_in = STAT_EMPTY;
                  end
               endcase

               // Pop the chosen head
               if (pop) begin
                  rsp_kind_in = pick;
                  if (pick) begin
                     rsp_date_in     = second_rd_ff;
                     second_head_in  = ptr_next(second_head_ff);
                     second_count_in = second_count_ff - CNT_W'(1);
                  end else begin
                     rsp_date_in    = first_rd_ff;
                     first_head_in  = ptr_next(first_head_ff);
                     first_count_in = first_count_ff - CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         first_head_ff   <= '0;
         first_tail_ff   <= '0;
         first_count_ff  <= '0;
         second_head_ff  <= '0;
         second_tail_ff  <= '0;
         second_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_head_ff   <= first_head_in;
         first_tail_ff   <= first_tail_in;
         first_count_ff  <= first_count_in;
         second_head_ff  <= second_head_in;
         second_tail_ff  <= second_tail_in;
         second_count_ff <= second_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_date_ff   <= rsp_date_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.out_kind  = rsp_kind_ff;
   assign rsp_ch.out_day   = rsp_date_ff[DAY_W-1:0];
   assign rsp_ch.out_month = rsp_date_ff[DAY_W +: MONTH_W];
   assign rsp_ch.out_year  = rsp_date_ff[DAY_W+MONTH_W +: YEAR_W];

endmodule

`default_nettype wire

// File: tb/sv/dual_fifo_oldest_first_dequeue_tb.sv
`default_nettype none

module dual_fifo_oldest_first_dequeue_tb;
   import dfq_pkg::*;

   localparam int unsigned DEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_WAIT  = 20;

   typedef struct packed {
      status_type         status;
      logic               kind;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } shelter_outcome_type;

   logic clock;
   logic reset;

   dfq_req_if req_ch ();
   dfq_rsp_if rsp_ch ();

   dual_fifo_oldest_first_dequeue #(
      .QUEUE_DEPTH(DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Shadow copy of both class queues
   logic [DATE_W-1:0] class_store [2][DEPTH];
   int unsigned       class_head  [2];
   int unsigned       class_tail  [2];
   int unsigned       class_count [2];

   shelter_outcome_type awaited_outcomes[$];

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned hold_off_cycles;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned responses_checked;
   int unsigned full_drops;
   int unsigned empty_replies;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the response to one request and advance the shadow queues
   function automatic shelter_outcome_type apply_request(command_type cmd, logic kind,
                                                         logic [DAY_W-1:0] day,
                                                         logic [MONTH_W-1:0] month,
                                                         logic [YEAR_W-1:0] year);
      shelter_outcome_type o;
      int unsigned         pick;
      logic [DATE_W-1:0]   date;
      o        = '0;
      o.status = STAT_OK;
      pick     = 0;
      if (cmd == CMD_ENQUEUE) begin
         if (class_count[kind] >= DEPTH) begin
            o.status = STAT_FULL;
         end else begin
            class_store[kind][class_tail[kind]] = {year, month, day};
            class_tail[kind]  = (class_tail[kind] + 1) % DEPTH;
            class_count[kind] = class_count[kind] + 1;
         end
         return o;
      end
      case (cmd)
         CMD_DEQ_OLDEST: begin
            if (class_count[0] == 0 && class_count[1] == 0) begin
               o.status = STAT_EMPTY;
               return o;
            end
            if (class_count[0] == 0)
               pick = 1;
            else if (class_count[1] == 0)
               pick = 0;
            else
               // Class 1 wins a tie: class 0 only when strictly older
               pick = (class_store[0][class_head[0]] < class_store[1][class_head[1]]) ? 0 : 1;
         end
         CMD_DEQ_FIRST:  pick = 0;
         default:        pick = 1;
      endcase
      if (class_count[pick] == 0) begin
         o.status = STAT_EMPTY;
         return o;
      end
      date              = class_store[pick][class_head[pick]];
      class_head[pick]  = (class_head[pick] + 1) % DEPTH;
      class_count[pick] = class_count[pick] - 1;
      o.kind            = pick[0];
      {o.year, o.month, o.day} = date;
      return o;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // Drive the response ready: long hold-off first, else random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Check each accepted response against the oldest awaited outcome
   always @(posedge clock) begin
      shelter_outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
            check_field("out_kind", 32'(want.kind), 32'(rsp_ch.out_kind));
            check_field("out_day", 32'(want.day), 32'(rsp_ch.out_day));
            check_field("out_month", 32'(want.month), 32'(rsp_ch.out_month));
            check_field("out_year", 32'(want.year), 32'(rsp_ch.out_year));
            responses_checked++;
            if (want.status == STAT_FULL)
               full_drops++;
            if (want.status == STAT_EMPTY)
               empty_replies++;
         end
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(command_type cmd, logic kind, logic [DAY_W-1:0] day,
                               logic [MONTH_W-1:0] month, logic [YEAR_W-1:0] year);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.kind    <= kind;
      req_ch.day     <= day;
      req_ch.month   <= month;
      req_ch.year    <= year;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      awaited_outcomes.push_back(apply_request(cmd, kind, day, month, year));
      requests_sent++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (awaited_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Mostly clustered dates so that ties and near ties are common
   task automatic random_date(output logic [DAY_W-1:0] day, output logic [MONTH_W-1:0] month,
                              output logic [YEAR_W-1:0] year);
      int unsigned mode;
      mode = $urandom_range(99);
      if (mode < 60) begin
         day   = DAY_W'($urandom_range(3, 1));
         month = MONTH_W'($urandom_range(2, 1));
         year  = YEAR_W'($urandom_range(2021, 2020));
      end else if (mode < 90) begin
         day   = DAY_W'($urandom_range(31, 1));
         month = MONTH_W'($urandom_range(12, 1));
         year  = YEAR_W'($urandom_range(9999, 0));
      end else begin
         day   = DAY_W'($urandom);
         month = MONTH_W'($urandom);
         year  = YEAR_W'($urandom);
      end
   endtask

   task automatic send_random_request(int unsigned enqueue_pct);
      command_type        cmd;
      logic               kind;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      random_date(day, month, year);
      kind = 1'($urandom_range(1));
      if ($urandom_range(99) < enqueue_pct)
         cmd = CMD_ENQUEUE;
      else
         case ($urandom_range(2))
            0:       cmd = CMD_DEQ_OLDEST;
            1:       cmd = CMD_DEQ_FIRST;
            default: cmd = CMD_DEQ_SECOND;
         endcase
      send_request(cmd, kind, day, month, year);
   endtask

   // Dequeues of every kind on empty queues, date fields ignored
   task automatic test_empty_queues();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(CMD_DEQ_OLDEST, 1'b1, '1, '1, '1);
      send_request(CMD_DEQ_FIRST, 1'b0, '0, '0, '0);
      send_request(CMD_DEQ_SECOND, 1'b1, 5'd31, 4'd12, 14'd9999);
      end_burst();
   endtask

   // Tie, single-queue, year, month and day decisions, then odd bit patterns
   task automatic test_date_ordering();
      send_request(CMD_ENQUEUE, 1'b0, 5'd10, 4'd5, 14'd2000);
      send_request(CMD_ENQUEUE, 1'b1, 5'd10, 4'd5, 14'd2000);
      send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      send_request(CMD_ENQUEUE, 1'b0, 5'd1, 4'd1, 14'd2001);
      send_request(CMD_ENQUEUE, 1'b1, 5'd31, 4'd12, 14'd2000);
      send_request(CMD_DEQ_OLDEST, 1'b1, '1, '1, '1);
      send_request(CMD_ENQUEUE, 1'b1, 5'd2, 4'd1, 14'd2001);
      send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      send_request(CMD_ENQUEUE, 1'b0, 5'd5, 4'd3, 14'd2002);
      send_request(CMD_ENQUEUE, 1'b1, 5'd28, 4'd2, 14'd2002);
      send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      send_request(CMD_ENQUEUE, 1'b1, 5'd31, 4'd15, 14'd16383);
      send_request(CMD_ENQUEUE, 1'b1, 5'd0, 4'd0, 14'd0);
      send_request(CMD_DEQ_SECOND, 1'b0, '0, '0, '0);
      send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      send_request(CMD_DEQ_FIRST, 1'b1, '0, '0, '0);
      send_request(CMD_DEQ_FIRST, 1'b0, '0, '0, '0);
      send_request(CMD_DEQ_SECOND, 1'b0, '0, '0, '0);
      end_burst();
   endtask

   // Overfill both classes, then drain them completely
   task automatic test_full_queues();
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      for (int i = 0; i < 2 * (DEPTH + 1); i++) begin
         random_date(day, month, year);
         send_request(CMD_ENQUEUE, i[0], day, month, year);
      end
      for (int i = 0; i <= 2 * DEPTH; i++)
         send_request(CMD_DEQ_OLDEST, 1'b0, '0, '0, '0);
      end_burst();
   endtask

   // Hold responses off while requests keep coming, then pause until drained
   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_cycles    = 300;
      for (int i = 0; i < 40; i++)
         send_random_request(60);
      end_burst();
      wait_drained();
   endtask

   // Random traffic with the enqueue share shifting so occupancy wanders
   task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                      int unsigned stall_pct);
      int unsigned enqueue_pct;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      enqueue_pct        = 50;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 30 == 0)
            case ($urandom_range(2))
               0:       enqueue_pct = 25;
               1:       enqueue_pct = 50;
               default: enqueue_pct = 75;
            endcase
         send_random_request(enqueue_pct);
      end
      end_burst();
   endtask

   // Give up on a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout with %0d responses outstanding", awaited_outcomes.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_ENQUEUE;
      req_ch.kind        = 1'b0;
      req_ch.day         = '0;
      req_ch.month       = '0;
      req_ch.year        = '0;
      rsp_ch.ready       = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_cycles    = 0;
      error_count        = 0;
      requests_sent      = 0;
      responses_checked  = 0;
      full_drops         = 0;
      empty_replies      = 0;
      for (int k = 0; k < 2; k++) begin
         class_head[k]  = 0;
         class_tail[k]  = 0;
         class_count[k] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queues();
      test_date_ordering();
      test_full_queues();
      test_backpressure();
      test_random_traffic(360, 0, 0);
      test_random_traffic(360, 63, 0);
      test_random_traffic(360, 0, 63);
      test_random_traffic(360, 29, 29);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d requests: directed ordering, full fill of both classes,",
               requests_sent);
      $display("a long response hold-off and four idling mixes; %0d full, %0d empty.",
               full_drops, empty_replies);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
